>>> src/signed_divider_three_modes_assert.svh
// Assertion macros used by the checker file.
`ifndef SIGNED_DIVIDER_THREE_MODES_ASSERT_SVH
`define SIGNED_DIVIDER_THREE_MODES_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SDTM_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed: label");

// Next-cycle implication, off during reset.
`define SDTM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked during reset as well.
`define SDTM_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("assertion failed: label");

`endif

>>> src/sdtm_pkg.sv
// ----------------------------------------------------------------------------
// sdtm_pkg
// Types and constants for the three-mode signed divider pipeline.
// ----------------------------------------------------------------------------
package sdtm_pkg;

  localparam int W = 64;
  localparam int HW = W / 2;

  localparam logic [1:0] CMD_S32_S32 = 2'd0;
  localparam logic [1:0] CMD_S64_S32 = 2'd1;
  localparam logic [1:0] CMD_S64_S64 = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  localparam logic [W-1:0] Q_ZERO32_NEG = 64'hFFFF_FFFF_0000_0001;
  localparam logic [W-1:0] Q_ZERO32_POS = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [W-1:0] r;       // partial remainder
    logic [W-1:0] q;       // dividend bits in, quotient bits out
    logic [W-1:0] d;       // divisor magnitude
    logic         neg_q;
    logic         neg_r;
    logic         zero32;  // 32-bit mode with zero divisor
    logic         dbz;
  } stage_t;

  function automatic logic [W-1:0] sext32(input logic [W-1:0] v);
    sext32 = {{HW{v[HW-1]}}, v[HW-1:0]};
  endfunction

endpackage

>>> src/sdtm_prep.sv
// ----------------------------------------------------------------------------
// sdtm_prep
// Operand decode: mode widths, magnitudes, result signs and flags.
// ----------------------------------------------------------------------------
module sdtm_prep (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               command,
  input  logic [sdtm_pkg::W-1:0]   numerator,
  input  logic [sdtm_pkg::W-1:0]   denominator,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sdtm_pkg::stage_t         out_data
);

  logic                   mode64;
  logic [sdtm_pkg::W-1:0] n;
  logic [sdtm_pkg::W-1:0] d;
  sdtm_pkg::stage_t       stage_next;

  assign in_stall = out_valid & out_stall;

  always_comb begin
    mode64 = (command == sdtm_pkg::CMD_S64_S32) || (command == sdtm_pkg::CMD_S64_S64);
    n = mode64 ? numerator : sdtm_pkg::sext32(numerator);
    d = (command == sdtm_pkg::CMD_S64_S64) ? denominator : sdtm_pkg::sext32(denominator);
    stage_next.r      = '0;
    stage_next.q      = n[sdtm_pkg::W-1] ? (~n + 1'b1) : n;
    stage_next.d      = d[sdtm_pkg::W-1] ? (~d + 1'b1) : d;
    stage_next.neg_q  = n[sdtm_pkg::W-1] ^ d[sdtm_pkg::W-1];
    stage_next.neg_r  = n[sdtm_pkg::W-1];
    stage_next.zero32 = !mode64 && (d == '0);
    stage_next.dbz    = (denominator == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_data <= stage_next;
    end
  end

endmodule

>>> src/sdtm_div_stage.sv
// ----------------------------------------------------------------------------
// sdtm_div_stage
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module sdtm_div_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sdtm_pkg::stage_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sdtm_pkg::stage_t out_data
);

  logic [sdtm_pkg::W:0] trial;
  logic [sdtm_pkg::W:0] diff;
  logic                 ge;
  sdtm_pkg::stage_t     stage_next;

  assign in_stall = out_valid & out_stall;

  always_comb begin
    trial = {in_data.r, in_data.q[sdtm_pkg::W-1]};
    diff  = trial - {1'b0, in_data.d};
    ge    = !diff[sdtm_pkg::W];
    stage_next   = in_data;
    stage_next.r = ge ? diff[sdtm_pkg::W-1:0] : trial[sdtm_pkg::W-1:0];
    stage_next.q = {in_data.q[sdtm_pkg::W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_data <= stage_next;
    end
  end

endmodule

>>> src/sdtm_post.sv
// ----------------------------------------------------------------------------
// sdtm_post
// Sign correction, 32-bit zero-divisor patterns and output register.
// ----------------------------------------------------------------------------
module sdtm_post (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sdtm_pkg::stage_t       in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [sdtm_pkg::W-1:0] quotient,
  output logic [sdtm_pkg::W-1:0] remainder,
  output logic                   divide_by_zero
);

  logic [sdtm_pkg::W-1:0] quotient_next;
  logic [sdtm_pkg::W-1:0] remainder_next;

  assign in_stall = out_valid & out_stall;

  always_comb begin
    quotient_next  = in_data.neg_q ? (~in_data.q + 1'b1) : in_data.q;
    remainder_next = in_data.neg_r ? (~in_data.r + 1'b1) : in_data.r;
    if (in_data.zero32) begin
      quotient_next = in_data.neg_r ? sdtm_pkg::Q_ZERO32_NEG : sdtm_pkg::Q_ZERO32_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      quotient       <= quotient_next;
      remainder      <= remainder_next;
      divide_by_zero <= in_data.dbz;
    end
  end

endmodule

>>> src/signed_divider_three_modes.sv
// ----------------------------------------------------------------------------
// signed_divider_three_modes
// Pipelined signed divider: 32/32, 64/32 and 64/64 modes.
// ----------------------------------------------------------------------------
// Request channel: in_valid / in_stall with command, numerator, denominator.
// Result channel: out_valid / out_stall with quotient, remainder and
// divide_by_zero. A transfer happens on a clock edge with valid high and
// stall low.
// The pipeline has one decode stage, 64 restoring division stages that
// each resolve one quotient bit with a 65-bit subtract, and one output stage.
// Throughput is one request per cycle unless stalled; 64 bit stages set depth.
// Each stage holds its own valid bit, so bubbles are squeezed out: when the
// receiver stalls, the pipeline keeps filling until every stage is occupied,
// then in_stall rises. Nothing is lost or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
// Division truncates toward zero; the remainder takes the numerator sign.
// Most-negative / -1 and zero divisors give fixed quotient patterns.
// ----------------------------------------------------------------------------
module signed_divider_three_modes (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  input  logic [sdtm_pkg::W-1:0] numerator,
  input  logic [sdtm_pkg::W-1:0] denominator,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [sdtm_pkg::W-1:0] quotient,
  output logic [sdtm_pkg::W-1:0] remainder,
  output logic                   divide_by_zero
);

  sdtm_pkg::stage_t stage_data  [0:sdtm_pkg::W];
  logic             stage_valid [0:sdtm_pkg::W];
  logic             stage_stall [0:sdtm_pkg::W];

  sdtm_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .numerator   (numerator),
    .denominator (denominator),
    .out_valid   (stage_valid[0]),
    .out_stall   (stage_stall[0]),
    .out_data    (stage_data[0])
  );

  for (genvar k = 0; k < sdtm_pkg::W; k++) begin : g_bit
    sdtm_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_stall  (stage_stall[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_stall (stage_stall[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  sdtm_post u_post (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (stage_valid[sdtm_pkg::W]),
    .in_stall       (stage_stall[sdtm_pkg::W]),
    .in_data        (stage_data[sdtm_pkg::W]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

endmodule

>>> src/sdtm_checker.sv
// ----------------------------------------------------------------------------
// sdtm_checker
// Port-level checks for the signed divider, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_divider_three_modes_assert.svh"

module sdtm_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [sdtm_pkg::W-1:0] quotient,
  input logic [sdtm_pkg::W-1:0] remainder,
  input logic                   divide_by_zero
);

  logic dbz_out;
  logic dbz_q_any;
  logic dbz_q_neg;
  logic dbz_q_pos;

  assign dbz_out   = out_valid && divide_by_zero;
  assign dbz_q_neg = (quotient == 64'd1) || (quotient == sdtm_pkg::Q_ZERO32_NEG);
  assign dbz_q_pos = (quotient == '1) || (quotient == sdtm_pkg::Q_ZERO32_POS);
  assign dbz_q_any = dbz_q_neg || dbz_q_pos;

  `SDTM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(quotient) && $stable(remainder))

  `SDTM_ASSERT_IMPLY(a_dbz_pattern, clk, rst, dbz_out, dbz_q_any)

  `SDTM_ASSERT_IMPLY(a_dbz_sign, clk, rst, dbz_out,
                     remainder[sdtm_pkg::W-1] ? dbz_q_neg : dbz_q_pos)

  `SDTM_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind signed_divider_three_modes sdtm_checker u_sdtm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .quotient       (quotient),
  .remainder      (remainder),
  .divide_by_zero (divide_by_zero)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-mode signed divider pipeline.
// Directed corner requests (overflow, zero divisor, divisor zero only in the
// low word, reserved command) are followed by random requests under several
// idle/stall mixes and one long receiver hold-off that backs up the pipeline.
// A scoreboard class predicts each result in order and compares all fields.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 100;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_NEG32   = 64'hFFFF_FFFF_8000_0000;

  typedef struct {
    logic [63:0] quotient;
    logic [63:0] remainder;
    logic        divide_by_zero;
  } division_result_t;

  class quotient_scoreboard;
    division_result_t pending[$];
    int requests;
    int results;
    int mismatches;

    function logic [63:0] widen_low_word(logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
    endfunction

    function division_result_t divide_three_modes(logic [1:0] cmd, logic [63:0] num,
                                                  logic [63:0] den);
      division_result_t res;
      logic [63:0] n, d, mn, md, mq, mr;
      res.divide_by_zero = (den == 64'd0);
      if (cmd == sdtm_pkg::CMD_S64_S32 || cmd == sdtm_pkg::CMD_S64_S64) begin
        n = num;
        d = (cmd == sdtm_pkg::CMD_S64_S64) ? den : widen_low_word(den);
      end else begin
        n = widen_low_word(num);
        d = widen_low_word(den);
      end
      if (cmd == sdtm_pkg::CMD_S64_S32 || cmd == sdtm_pkg::CMD_S64_S64) begin
        if (n == MOST_NEG && d == ALL_ONES) begin
          res.quotient = MOST_NEG;
          res.remainder = 64'd0;
          return res;
        end
        if (d == 64'd0) begin
          res.quotient = n[63] ? 64'd1 : ALL_ONES;
          res.remainder = n;
          return res;
        end
      end else begin
        if (n == MOST_NEG32 && d == ALL_ONES) begin
          res.quotient = 64'h0000_0000_8000_0000;
          res.remainder = 64'd0;
          return res;
        end
        if (d == 64'd0) begin
          res.quotient = n[63] ? sdtm_pkg::Q_ZERO32_NEG : sdtm_pkg::Q_ZERO32_POS;
          res.remainder = n;
          return res;
        end
      end
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      mq = mn / md;
      mr = mn % md;
      res.quotient = (n[63] != d[63]) ? -mq : mq;
      res.remainder = n[63] ? -mr : mr;
      return res;
    endfunction

    function void note_request(logic [1:0] cmd, logic [63:0] num, logic [63:0] den);
      pending.push_back(divide_three_modes(cmd, num, den));
      requests++;
    endfunction

    function void check_result(logic [63:0] q, logic [63:0] r, logic dbz);
      division_result_t want;
      results++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: quotient %h remainder %h", q, r);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (q !== want.quotient) begin
        $error("quotient expected %h actual %h", want.quotient, q);
        mismatches++;
      end
      if (r !== want.remainder) begin
        $error("remainder expected %h actual %h", want.remainder, r);
        mismatches++;
      end
      if (dbz !== want.divide_by_zero) begin
        $error("divide_by_zero expected %b actual %b", want.divide_by_zero, dbz);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = sdtm_pkg::CMD_S32_S32;
  logic [63:0] numerator = 64'd0;
  logic [63:0] denominator = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] quotient;
  logic [63:0] remainder;
  logic        divide_by_zero;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit hold_off = 1'b0;
  int cycle_count = 0;
  int stalled_inputs = 0;

  quotient_scoreboard sb = new();

  signed_divider_three_modes uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .numerator(numerator),
    .denominator(denominator),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .quotient(quotient),
    .remainder(remainder),
    .divide_by_zero(divide_by_zero)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending.size());
      $display("[signed_divider_three_modes] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(command, numerator, denominator);
      if (in_valid && in_stall) stalled_inputs++;
      if (out_valid && !out_stall) sb.check_result(quotient, remainder, divide_by_zero);
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
  end

  task automatic send_request(logic [1:0] cmd, logic [63:0] num, logic [63:0] den);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    numerator <= num;
    denominator <= den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_phase(int idle_pct, int stall_pct);
    in_valid <= 1'b0;
    @(posedge clk);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    @(negedge clk);
  endtask

  task automatic hold_receiver(int cycles);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(7))
      0: v = {$urandom, $urandom};
      1: begin
        v = 64'($urandom_range(20));
        if ($urandom_range(1)) v = -v;
      end
      2: v = {{32{1'b0}}, $urandom};
      3: begin
        v = {{32{1'b0}}, $urandom};
        v = {{32{v[31]}}, v[31:0]};
      end
      4: begin
        case ($urandom_range(7))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = ALL_ONES;
          3: v = MOST_NEG;
          4: v = 64'h0000_0000_8000_0000;
          5: v = MOST_NEG32;
          6: v = 64'h7FFF_FFFF_FFFF_FFFF;
          default: v = 64'h0000_0000_7FFF_FFFF;
        endcase
      end
      5: v = {$urandom, 32'd0};
      6: v = {{32{1'b0}}, 16'd0, 16'($urandom)};
      default: v = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    return v;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(2'($urandom_range(3)), pick_operand(), pick_operand());
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    send_request(sdtm_pkg::CMD_S32_S32, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(sdtm_pkg::CMD_S32_S32, 64'hDEAD_BEEF_8000_0000, 64'h1234_5678_FFFF_FFFF);
    send_request(sdtm_pkg::CMD_S32_S32, 64'h0000_0000_FFFF_FFFB, 64'd0);
    send_request(sdtm_pkg::CMD_S32_S32, 64'd5, 64'd0);
    send_request(sdtm_pkg::CMD_S32_S32, 64'd5, 64'h0000_0001_0000_0000);
    send_request(sdtm_pkg::CMD_S32_S32, ALL_ONES, ALL_ONES);
    send_request(sdtm_pkg::CMD_S32_S32, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000);
    send_request(sdtm_pkg::CMD_RSVD, 64'h0000_0000_8000_0000, ALL_ONES);
    send_request(sdtm_pkg::CMD_RSVD, 64'hFFFF_FFFF_FFFF_FF9C, 64'd7);
    send_request(sdtm_pkg::CMD_S64_S32, MOST_NEG, 64'h0000_0000_FFFF_FFFF);
    send_request(sdtm_pkg::CMD_S64_S32, 64'hFFFF_FFFF_FFFF_FFF7, 64'd2);
    send_request(sdtm_pkg::CMD_S64_S32, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_7FFF_FFFF);
    send_request(sdtm_pkg::CMD_S64_S32, MOST_NEG32, 64'd0);
    send_request(sdtm_pkg::CMD_S64_S32, 64'd1000, 64'h0000_ABCD_0000_0000);
    send_request(sdtm_pkg::CMD_S64_S32, 64'h0123_4567_89AB_CDEF, 64'h0000_0001_8000_0000);
    send_request(sdtm_pkg::CMD_S64_S64, MOST_NEG, ALL_ONES);
    send_request(sdtm_pkg::CMD_S64_S64, MOST_NEG, 64'd1);
    send_request(sdtm_pkg::CMD_S64_S64, MOST_NEG, 64'd2);
    send_request(sdtm_pkg::CMD_S64_S64, 64'd12345, 64'd0);
    send_request(sdtm_pkg::CMD_S64_S64, MOST_NEG, 64'd0);
    send_request(sdtm_pkg::CMD_S64_S64, ALL_ONES, ALL_ONES);
    send_request(sdtm_pkg::CMD_S64_S64, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES);
    send_request(sdtm_pkg::CMD_S64_S64, 64'd0, 64'd5);
    send_request(sdtm_pkg::CMD_S64_S64, 64'h7FFF_FFFF_FFFF_FFFF, MOST_NEG);

    set_phase(0, 0);
    run_random(150);
    set_phase(48, 0);
    run_random(150);
    set_phase(0, 48);
    run_random(150);
    set_phase(14, 14);
    run_random(150);

    // receiver holds off long enough to fill the pipeline
    set_phase(0, 0);
    fork
      hold_receiver(300);
      run_random(150);
    join

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d requests over all modes and corner operands",
             sb.results, sb.requests);
    $display("idle, stall and hold-off phases ran; input stalled on %0d cycles",
             stalled_inputs);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[signed_divider_three_modes] OK");
    end else begin
      $display("[signed_divider_three_modes] ERROR");
    end
    $finish;
  end
endmodule
